>>> rtl/core/dac_pkg.sv
package dac_pkg;

	// Field widths of the request, result and configuration channels.
	localparam int unsigned ADDR_W       = 12;
	localparam int unsigned DATA_W       = 8;
	localparam int unsigned LEN_W        = 13;
	localparam int unsigned PERIOD_W     = 16;
	localparam int unsigned VOL_W        = 7;
	localparam int unsigned PWM_W        = 6;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 16;

	// Default sample memory depth, a power of two.
	localparam int unsigned DEFAULT_SAMPLE_DEPTH = 4096;

	// Register values after reset.
	localparam logic [LEN_W-1:0]    RST_SAMPLE_LENGTH = LEN_W'(1);
	localparam logic [PERIOD_W-1:0] RST_PERIOD        = PERIOD_W'(124);
	localparam logic [VOL_W-1:0]    RST_VOLUME        = VOL_W'(64);
	localparam logic [LEN_W-1:0]    RST_BYTES_LEFT    = LEN_W'(1);

	// Request kinds.
	typedef enum logic {
		REQ_TICK  = 1'b0,
		REQ_WRITE = 1'b1
	} req_kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DMA_ENABLE    = 3'd0,
		CFG_IRQ_ENABLE    = 3'd1,
		CFG_START_ADDRESS = 3'd2,
		CFG_SAMPLE_LENGTH = 3'd3,
		CFG_PERIOD        = 3'd4,
		CFG_VOLUME        = 3'd5
	} cfg_reg_t;

	// Control bits that travel with a tick from the fetch stage to the output stage.
	typedef struct packed {
		logic fetch;
		logic gate;
		logic irq;
		logic running;
	} tick_ctrl_t;

endpackage

>>> rtl/core/dac_req_if.sv
interface dac_req_if;
	import dac_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [ADDR_W-1:0]        write_address;
	logic signed [DATA_W-1:0] write_data;

	modport source (output valid, req_type, write_address, write_data, input ready);
	modport sink (input valid, req_type, write_address, write_data, output ready);
endinterface

>>> rtl/core/dac_res_if.sv
interface dac_res_if;
	import dac_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample_out;
	logic                     irq_pulse;
	logic                     channel_running;

	modport source (output valid, sample_out, irq_pulse, channel_running, input ready);
	modport sink (input valid, sample_out, irq_pulse, channel_running, output ready);
endinterface

>>> rtl/core/dac_cfg_if.sv
interface dac_cfg_if;
	import dac_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/dma_audio_channel.sv
// A tick's result passes through stage 1 and the output register. One request
// (tick or sample write) is taken per cycle when not stalled; the single read port
// of the sample memory serves at most one fetch per tick, and the output register
// lets a new request in while a finished result waits. Sample writes give no
// result. Reset initialises the channel counters, the registers and the pipeline;
// the sample memory is not cleared and holds undefined data until written.
module dma_audio_channel #(
	parameter int unsigned SAMPLE_DEPTH = dac_pkg::DEFAULT_SAMPLE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	dac_cfg_if.sink   cfg,
	dac_req_if.sink   req,
	dac_res_if.source res
);
	import dac_pkg::*;

	localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

	// Configuration registers.
	logic                dma_enable_q;
	logic                irq_enable_q;
	logic [ADDR_W-1:0]   start_address_q;
	logic [LEN_W-1:0]    sample_length_q;
	logic [PERIOD_W-1:0] period_q;
	logic [VOL_W-1:0]    volume_q;

	// Channel state.
	logic                fetch_running_q;
	logic [AW-1:0]       fetch_address_q;
	logic [LEN_W-1:0]    bytes_left_q;
	logic [PERIOD_W-1:0] period_countdown_q;
	logic [PWM_W-1:0]    pwm_phase_q;
	logic [DATA_W-1:0]   current_sample_q;

	// Sample memory with a registered read port.
	logic [DATA_W-1:0]   sample_mem [SAMPLE_DEPTH];
	logic [DATA_W-1:0]   rdata_q;

	// Pipeline and output register.
	logic                valid_s1;
	tick_ctrl_t          ctrl_s1;
	logic                res_valid_q;
	logic [DATA_W-1:0]   res_sample_q;
	logic                res_irq_q;
	logic                res_running_q;

	// Next-state values of the fetch stage.
	logic                req_fire;
	logic                tick_fire;
	logic                write_fire;
	logic                s1_adv;
	logic                running_d;
	logic [AW-1:0]       addr_d;
	logic [LEN_W-1:0]    left_d;
	logic [PERIOD_W-1:0] countdown_d;
	logic [PWM_W-1:0]    pwm_d;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       start_addr;
	tick_ctrl_t          ctrl_d;
	logic [DATA_W-1:0]   sample_sel;

	// Handshake: the fetch stage moves on whenever the output register is free.
	assign s1_adv     = !res_valid_q || res.ready;
	assign req.ready  = !valid_s1 || s1_adv;
	assign req_fire   = req.valid && req.ready;
	assign tick_fire  = req_fire && (req.req_type == REQ_TICK);
	assign write_fire = req_fire && (req.req_type == REQ_WRITE);
	assign cfg.ready  = 1'b1;
	assign start_addr = AW'(start_address_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dma_enable_q    <= 1'b0;
			irq_enable_q    <= 1'b0;
			start_address_q <= '0;
			sample_length_q <= RST_SAMPLE_LENGTH;
			period_q        <= RST_PERIOD;
			volume_q        <= RST_VOLUME;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DMA_ENABLE:    dma_enable_q    <= cfg.data[0];
				CFG_IRQ_ENABLE:    irq_enable_q    <= cfg.data[0];
				CFG_START_ADDRESS: start_address_q <= cfg.data[ADDR_W-1:0];
				CFG_SAMPLE_LENGTH: sample_length_q <= cfg.data[LEN_W-1:0];
				CFG_PERIOD:        period_q        <= cfg.data[PERIOD_W-1:0];
				CFG_VOLUME:        volume_q        <= cfg.data[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Fetch stage: restart, period divider, byte fetch and PWM phase for one tick.
	always_comb begin
		running_d   = fetch_running_q;
		addr_d      = fetch_address_q;
		left_d      = bytes_left_q;
		countdown_d = period_countdown_q;
		pwm_d       = pwm_phase_q;
		rd_addr     = fetch_address_q;
		ctrl_d      = '0;
		if (!dma_enable_q) begin
			running_d = 1'b0;
		end else begin
			running_d = 1'b1;
			if (!fetch_running_q) begin
				addr_d     = start_addr;
				left_d     = sample_length_q;
				ctrl_d.irq = irq_enable_q;
			end
			if (volume_q != '0) begin
				if (countdown_d == '0) begin
					countdown_d  = period_q;
					ctrl_d.fetch = 1'b1;
					rd_addr      = addr_d;
					addr_d       = addr_d + AW'(1);
					if (left_d <= LEN_W'(1)) begin
						addr_d     = start_addr;
						left_d     = sample_length_q;
						ctrl_d.irq = ctrl_d.irq | irq_enable_q;
					end else begin
						left_d = left_d - LEN_W'(1);
					end
				end
				ctrl_d.gate = {1'b0, pwm_phase_q} < volume_q;
				pwm_d       = pwm_phase_q + PWM_W'(1);
				countdown_d = countdown_d - PERIOD_W'(1);
			end
		end
		ctrl_d.running = running_d;
	end

	// Channel state updates on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_running_q    <= 1'b0;
			fetch_address_q    <= '0;
			bytes_left_q       <= RST_BYTES_LEFT;
			period_countdown_q <= '0;
			pwm_phase_q        <= '0;
		end else if (tick_fire) begin
			fetch_running_q    <= running_d;
			fetch_address_q    <= addr_d;
			bytes_left_q       <= left_d;
			period_countdown_q <= countdown_d;
			pwm_phase_q        <= pwm_d;
		end
	end

	// Sample memory: host writes and the tick fetch share the request slot.
	always_ff @(posedge clk) begin
		if (write_fire) begin
			sample_mem[AW'(req.write_address)] <= req.write_data;
		end
		if (tick_fire && ctrl_d.fetch) begin
			rdata_q <= sample_mem[rd_addr];
		end
	end

	// Stage 1 holds the tick's control bits while the read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctrl_s1  <= '0;
		end else if (req_fire) begin
			valid_s1 <= tick_fire;
			ctrl_s1  <= ctrl_d;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// A fresh fetch replaces the held sample for this very tick.
	assign sample_sel = ctrl_s1.fetch ? rdata_q : current_sample_q;

	// Output register and held sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q      <= 1'b0;
			current_sample_q <= '0;
		end else if (s1_adv) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				current_sample_q <= sample_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			res_sample_q  <= ctrl_s1.gate ? sample_sel : '0;
			res_irq_q     <= ctrl_s1.irq;
			res_running_q <= ctrl_s1.running;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.sample_out      = res_sample_q;
	assign res.irq_pulse       = res_irq_q;
	assign res.channel_running = res_running_q;

endmodule
